[src/akf_pkg.sv]
// akf_pkg: shared types, constants and helpers for the three-axis attitude filter
// used by akf_div and attitude_kalman_filter_3axis; no dependencies
`timescale 1ns / 1ps

package akf_pkg;

  localparam int N_ST  = 3;
  localparam int N_EL  = N_ST * N_ST;
  localparam int DW    = 32;
  localparam int MW    = 34;
  localparam int PW    = 2 * MW;
  localparam int CW    = 64;
  localparam int FRAC  = 28;
  localparam int CLIM  = 29;

  localparam logic [2:0] REG_TIME_STEP     = 3'd0;
  localparam logic [2:0] REG_PNOISE_YAW    = 3'd1;
  localparam logic [2:0] REG_PNOISE_PITCH  = 3'd2;
  localparam logic [2:0] REG_PNOISE_ROLL   = 3'd3;
  localparam logic [2:0] REG_MNOISE_YAW    = 3'd4;
  localparam logic [2:0] REG_MNOISE_PITCH  = 3'd5;
  localparam logic [2:0] REG_MNOISE_ROLL   = 3'd6;

  localparam logic [28:0] RST_TIME_STEP    = 29'd1342177;
  localparam logic [30:0] RST_PNOISE_YAW   = 31'd2684;
  localparam logic [30:0] RST_PNOISE_PR    = 31'd268;
  localparam logic [30:0] RST_MNOISE_YAW   = 31'd2684355;
  localparam logic [30:0] RST_MNOISE_PR    = 31'd268435;

  localparam logic signed [PW-1:0] S32_MAX = PW'(64'sd2147483647);
  localparam logic signed [PW-1:0] S32_MIN = PW'(-64'sd2147483648);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRED, ST_COF, ST_SHIFT, ST_DET, ST_NUM, ST_DIV, ST_XUPD, ST_PUPD, ST_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic signed [CW-1:0] num;
    logic signed [CW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] q;
  } div_rsp_t;

  // arithmetic shift by FRAC, round half up
  function automatic logic signed [PW-1:0] rnd28(input logic signed [PW-1:0] v);
    return (v >>> FRAC) + $signed({{(PW-1){1'b0}}, v[FRAC-1]});
  endfunction

  function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    if (v > S32_MAX) r = S32_MAX;
    else if (v < S32_MIN) r = S32_MIN;
    else r = v;
    return r[DW-1:0];
  endfunction

  function automatic logic [1:0] row3(input logic [3:0] e);
    logic [1:0] r;
    case (e)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] col3(input logic [3:0] e);
    logic [1:0] r;
    case (e)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] inc3(input logic [1:0] a);
    return (a == 2'd2) ? 2'd0 : a + 2'd1;
  endfunction

  function automatic logic [3:0] el(input logic [1:0] r, input logic [1:0] cc);
    return 4'(r) * 4'd3 + 4'(cc);
  endfunction

endpackage

[src/akf_div.sv]
// akf_div: restoring divider for the gain entries, one quotient bit per cycle
// result is num/den in Q4.28, truncated toward zero and saturated; uses akf_pkg
`timescale 1ns / 1ps

module akf_div import akf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int QB = DW - 1;

  logic            busy;
  logic            done;
  logic [4:0]      cnt;
  logic [CW:0]     rem;
  logic [CW-1:0]   dm;
  logic [QB-1:0]   bits;
  logic [QB-1:0]   q;
  logic            neg;
  logic            ovf;
  logic [CW-1:0]   nmag;
  logic [CW-1:0]   dmag;
  logic [CW:0]     trial;
  logic            ge;

  assign nmag  = req.num[CW-1] ? CW'(-req.num) : CW'(req.num);
  assign dmag  = req.den[CW-1] ? CW'(-req.den) : CW'(req.den);
  assign trial = {rem[CW-1:0], bits[QB-1]};
  assign ge    = trial >= {1'b0, dm};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        neg <= req.num[CW-1] ^ req.den[CW-1];
        dm  <= dmag;
        q   <= '0;
        // quotient of eight or more cannot fit Q4.28
        if ({3'b000, nmag} >= {dmag, 3'b000}) begin
          ovf  <= 1'b1;
          done <= 1'b1;
        end else begin
          ovf  <= 1'b0;
          busy <= 1'b1;
          cnt  <= 5'(QB);
          rem  <= {4'd0, nmag[CW-1:3]};
          bits <= {nmag[2:0], {FRAC{1'b0}}};
        end
      end else if (busy) begin
        rem  <= ge ? trial - {1'b0, dm} : trial;
        q    <= {q[QB-2:0], ge};
        bits <= {bits[QB-2:0], 1'b0};
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    if (ovf) rsp.q = neg ? S32_MIN[DW-1:0] : S32_MAX[DW-1:0];
    else     rsp.q = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

endmodule

[src/attitude_kalman_filter_3axis.sv]
// attitude_kalman_filter_3axis: three-state Kalman filter for yaw, pitch and roll
// depends on akf_pkg and akf_div
`timescale 1ns / 1ps
//
// Input word on s_*: three gyro rates and three measured angles (Q12.20).
// Output word on m_*: the three fused angles (Q12.20, saturated), one per input.
// Configuration: cfg_we writes cfg_data to register cfg_index in the same cycle
// (0 dt, 1..3 process noise, 4..6 measurement noise, all Q4.28); write only
// while idle. Indexes beyond the list are ignored.
// All products go through one 34x34 multiplier; each product term is registered,
// then accumulated; the gain entries go through one bit-serial divider.
// An item runs from accept to a valid result through predict, cofactor,
// cofactor scaling, determinant, then each gain numerator followed by its
// divide (skipped when the determinant is zero), state and covariance update,
// and the load of the output; the block then returns to idle to take a word.
// s_tready is high only while idle; an accepted word is worked on alone.
// The result waits in an output register; a stalled receiver holds the block
// at its last step until that register frees, then the next word is taken.
// Reset clears the estimate and covariance to zero and loads default registers.

module attitude_kalman_filter_3axis import akf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // rate_x, rate_y, rate_z, meas_yaw, meas_pitch, meas_roll
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // est_yaw, est_pitch, est_roll
  output logic [95:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  logic [28:0]          dt;
  logic [30:0]          qn [N_ST];
  logic [30:0]          rn [N_ST];

  logic signed [DW-1:0] rate [N_ST];
  logic signed [DW-1:0] meas [N_ST];
  logic signed [DW-1:0] x    [N_ST];
  logic signed [DW-1:0] xm   [N_ST];
  logic signed [DW:0]   y    [N_ST];
  logic signed [DW-1:0] p    [N_EL];
  logic signed [DW-1:0] pm   [N_EL];
  logic signed [DW-1:0] s    [N_EL];
  logic signed [DW-1:0] k    [N_EL];
  logic signed [CW-1:0] c    [N_EL];
  logic signed [DW-1:0] pm_in [N_EL];
  logic signed [DW-1:0] s_in  [N_EL];
  logic signed [CW-1:0] det;
  logic [CW-1:0]        maxc;
  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] preg;

  state_t               state, state_next;
  logic [3:0]           idx;
  logic [1:0]           term;
  logic                 ph;

  logic signed [MW-1:0] opa, opb;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] addend, base, acc_new;
  logic signed [DW-1:0] sat_new;
  logic [CW-1:0]        cmag;
  logic [1:0]           last_term;
  logic                 mac_st, step_done, idx_last, out_load, scale_more;
  logic [1:0]           ri, cj, i1, i2, j1, j2;
  logic                 out_valid;
  logic [95:0]          out_data;
  div_req_t             dreq;
  div_rsp_t             drsp;

  akf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dt    <= RST_TIME_STEP;
      qn[0] <= RST_PNOISE_YAW;
      qn[1] <= RST_PNOISE_PR;
      qn[2] <= RST_PNOISE_PR;
      rn[0] <= RST_MNOISE_YAW;
      rn[1] <= RST_MNOISE_PR;
      rn[2] <= RST_MNOISE_PR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIME_STEP:    dt    <= cfg_data[28:0];
        REG_PNOISE_YAW:   qn[0] <= cfg_data;
        REG_PNOISE_PITCH: qn[1] <= cfg_data;
        REG_PNOISE_ROLL:  qn[2] <= cfg_data;
        REG_MNOISE_YAW:   rn[0] <= cfg_data;
        REG_MNOISE_PITCH: rn[1] <= cfg_data;
        REG_MNOISE_ROLL:  rn[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // predicted covariance and innovation covariance, taken at accept
  always_comb begin
    for (int e = 0; e < N_EL; e++) begin
      if (row3(4'(e)) == col3(4'(e))) begin
        pm_in[e] = sat32(PW'(p[e]) + $signed({{(PW-31){1'b0}}, qn[row3(4'(e))]}));
        s_in[e]  = sat32(PW'(pm_in[e]) + $signed({{(PW-31){1'b0}}, rn[row3(4'(e))]}));
      end else begin
        pm_in[e] = p[e];
        s_in[e]  = pm_in[e];
      end
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    ri  = row3(idx);
    cj  = col3(idx);
    i1  = inc3(ri);
    i2  = inc3(i1);
    j1  = inc3(cj);
    j2  = inc3(j1);
    opa = '0;
    opb = '0;
    unique case (state)
      ST_PRED: begin
        opa = $signed({5'd0, dt});
        opb = MW'(rate[idx[1:0]]);
      end
      ST_COF: begin
        if (term == 2'd0) begin
          opa = MW'(s[el(i1, j1)]);
          opb = MW'(s[el(i2, j2)]);
        end else begin
          opa = MW'(s[el(i1, j2)]);
          opb = MW'(s[el(i2, j1)]);
        end
      end
      ST_DET: begin
        opa = MW'(s[el(2'd0, term)]);
        opb = c[el(2'd0, term)][MW-1:0];
      end
      ST_NUM: begin
        opa = MW'(pm[el(ri, term)]);
        opb = c[el(cj, term)][MW-1:0];
      end
      ST_XUPD: begin
        opa = MW'(k[el(idx[1:0], term)]);
        opb = MW'(y[term]);
      end
      ST_PUPD: begin
        opa = MW'(k[el(ri, term)]);
        opb = MW'(pm[el(term, cj)]);
      end
      default: ;
    endcase
  end

  assign prod = opa * opb;

  always_comb begin
    mac_st = (state == ST_PRED) || (state == ST_COF) || (state == ST_DET) ||
             (state == ST_NUM) || (state == ST_XUPD) || (state == ST_PUPD);
    if (state == ST_PRED) last_term = 2'd0;
    else if (state == ST_COF) last_term = 2'd1;
    else last_term = 2'd2;
    step_done = mac_st && ph && (term == last_term);
    if ((state == ST_PRED) || (state == ST_XUPD)) idx_last = (idx == 4'd2);
    else if (state == ST_DET) idx_last = 1'b1;
    else idx_last = (idx == 4'(N_EL - 1));

    if ((state == ST_PRED) || (state == ST_XUPD) || (state == ST_PUPD))
      addend = rnd28(preg);
    else if ((state == ST_COF) && (term == 2'd1))
      addend = -preg;
    else
      addend = preg;

    if (term != 2'd0) base = acc;
    else if (state == ST_PRED) base = PW'(x[idx[1:0]]);
    else if (state == ST_XUPD) base = PW'(xm[idx[1:0]]);
    else base = '0;

    acc_new    = base + addend;
    sat_new    = sat32(acc_new);
    cmag       = acc_new[CW-1] ? CW'(-acc_new[CW-1:0]) : acc_new[CW-1:0];
    scale_more = (maxc[CW-1:CLIM] != '0);
    out_load   = (state == ST_OUT) && (!out_valid || m_tready);

    dreq.start = (state == ST_NUM) && step_done && (det != '0);
    dreq.num   = acc_new[CW-1:0];
    dreq.den   = det;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_PRED;
      ST_PRED:  if (step_done && idx_last) state_next = ST_COF;
      ST_COF:   if (step_done && idx_last) state_next = ST_SHIFT;
      ST_SHIFT: if (!scale_more) state_next = ST_DET;
      ST_DET:   if (step_done) state_next = ST_NUM;
      ST_NUM: begin
        if (step_done) begin
          if (det != '0) state_next = ST_DIV;
          else if (idx_last) state_next = ST_XUPD;
        end
      end
      ST_DIV: begin
        if (drsp.done) state_next = (idx == 4'(N_EL - 1)) ? ST_XUPD : ST_NUM;
      end
      ST_XUPD:  if (step_done && idx_last) state_next = ST_PUPD;
      ST_PUPD:  if (step_done && idx_last) state_next = ST_OUT;
      ST_OUT:   if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      term <= '0;
      ph   <= 1'b0;
      for (int i = 0; i < N_ST; i++) x[i] <= '0;
      for (int e = 0; e < N_EL; e++) p[e] <= '0;
    end else begin
      if ((state == ST_IDLE) && s_tvalid) begin
        for (int i = 0; i < N_ST; i++) begin
          rate[i] <= s_tdata[DW*i +: DW];
          meas[i] <= s_tdata[DW*(N_ST+i) +: DW];
        end
        pm   <= pm_in;
        s    <= s_in;
        idx  <= '0;
        term <= '0;
        ph   <= 1'b0;
      end

      if (mac_st) begin
        ph <= ~ph;
        if (!ph) begin
          preg <= prod;
        end else begin
          acc <= acc_new;
          if (term == last_term) begin
            term <= '0;
            if (!((state == ST_NUM) && (det != '0)))
              idx <= idx_last ? 4'd0 : idx + 4'd1;
            unique case (state)
              ST_PRED: begin
                xm[idx[1:0]] <= sat_new;
                y[idx[1:0]]  <= (DW+1)'(meas[idx[1:0]]) - (DW+1)'(sat_new);
                if (idx_last) maxc <= '0;
              end
              ST_COF: begin
                c[idx] <= acc_new[CW-1:0];
                if (cmag > maxc) maxc <= cmag;
              end
              ST_DET:  det <= acc_new[CW-1:0];
              ST_NUM:  if (det == '0) k[idx] <= '0;
              ST_XUPD: x[idx[1:0]] <= sat_new;
              ST_PUPD: p[idx] <= sat32(PW'(pm[idx]) - acc_new);
              default: ;
            endcase
          end else begin
            term <= term + 2'd1;
          end
        end
      end

      // bring every cofactor below 2**CLIM in magnitude, one bit a cycle
      if ((state == ST_SHIFT) && scale_more) begin
        maxc <= maxc >> 1;
        for (int e = 0; e < N_EL; e++) c[e] <= c[e] >>> 1;
      end

      if ((state == ST_DIV) && drsp.done) begin
        k[idx] <= drsp.q;
        idx    <= (idx == 4'(N_EL - 1)) ? 4'd0 : idx + 4'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= {x[2], x[1], x[0]};
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

[src/akf_check.sv]
// akf_check: port-level checks for attitude_kalman_filter_3axis
// bound to the top level below; no package needed
`timescale 1ns / 1ps

module akf_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata
);

  // a taken word keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again right after an accept");

  // no result can appear in the cycle after an input word
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result appeared too soon after input");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

endmodule

bind attitude_kalman_filter_3axis akf_check u_akf_check (.*);
